>>> rtl/krt_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed record table: sizes, codes, the record type and the FSM states.
// No dependencies; the core, chain, cell and testbench files import it.
package krt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ADJUST = 3'd1,
    OP_PRICE  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0]        key;
    logic signed [31:0] qty;
    logic [23:0]        price;
  } record_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL_OLD,
    S_MUL_NEW,
    S_ADD,
    S_FINISH
  } state_t;

endpackage

>>> rtl/krt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats of the record table.
// No dependencies.
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] item_key;
  logic signed [31:0] quantity_amount;
  logic [23:0]        price_cents;

  modport source (output valid, operation, item_key, quantity_amount, price_cents,
                  input ready);
  modport sink (input valid, operation, item_key, quantity_amount, price_cents,
                output ready);
endinterface

interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [55:0] item_value;
  logic signed [62:0] total_value;
  logic [7:0]         entry_count;

  modport source (output valid, status, item_value, total_value, entry_count,
                  input ready);
  modport sink (input valid, status, item_value, total_value, entry_count,
                output ready);
endinterface

>>> rtl/keyed_record_table_core.sv
`timescale 1ns / 1ps
// Top level of the keyed record table: request decode, walk sequencer, multiplier and result.
// Depends on krt_pkg, krt_if, krt_chain and krt_cell.

// The records live in a circular chain of TABLE_DEPTH cells that rotates one place per cycle
// while a request walks. Each request takes one full rotation, during which the head cell is
// compared, updated, appended to or closed up on removal; then the states S_MUL_OLD, S_MUL_NEW
// and S_ADD share one multiplier to value the old and new record and update the running total,
// and S_FINISH loads the result register once it is free or its response is being taken. A new
// request is taken only in S_IDLE, after the previous one has loaded its result, and it is
// taken while the previous response still waits.
module keyed_record_table_core (
  input logic     clk,
  input logic     rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);
  import krt_pkg::*;

  state_t state, state_next;

  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   count;
  logic signed [62:0] total;

  logic [2:0]         req_op;
  logic [31:0]        req_key;
  logic signed [31:0] req_amount;
  logic [23:0]        req_price;

  logic found;
  logic ins_done;
  logic removing;

  logic signed [31:0] old_q, new_q;
  logic [23:0]        old_p, new_p;
  logic signed [55:0] prod;

  logic sub_en, add_en, show_en;
  status_t status_r;

  logic               out_valid;
  status_t            out_status;
  logic signed [55:0] out_value;
  logic signed [62:0] out_total;
  logic [7:0]         out_count;

  logic    shift_en;
  logic    accept;
  record_t head, head_next, tail_in;

  logic               idx_valid;
  logic               hit;
  logic               at_end;
  logic               do_insert;
  logic               remove_now;
  logic signed [32:0] qty_sum;
  logic signed [31:0] qty_sat;
  record_t            hit_rec;

  logic signed [31:0] mul_q;
  logic [23:0]        mul_p;
  logic signed [56:0] mul_full;
  logic signed [62:0] prod_ext;

  logic is_insert, is_adjust, is_price, is_remove;

  krt_chain u_chain (
    .clk       (clk),
    .shift_en  (shift_en),
    .tail_in   (tail_in),
    .head      (head),
    .head_next (head_next)
  );

  assign is_insert = (req_op == OP_INSERT);
  assign is_adjust = (req_op == OP_ADJUST);
  assign is_price  = (req_op == OP_PRICE);
  assign is_remove = (req_op == OP_REMOVE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req.valid) state_next = S_WALK;
      S_WALK:    if (idx == LAST_IDX) state_next = S_MUL_OLD;
      S_MUL_OLD: state_next = S_MUL_NEW;
      S_MUL_NEW: state_next = S_ADD;
      S_ADD:     state_next = S_FINISH;
      S_FINISH:  if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    shift_en  = (state == S_WALK);
  end

  assign accept = req.valid && req.ready;

  always_comb begin
    idx_valid  = (CNT_W'(idx) < count);
    hit        = idx_valid && (head.key == req_key) && !found;
    at_end     = (CNT_W'(idx) == count);
    do_insert  = is_insert && at_end && !found && !ins_done;
    remove_now = removing || (is_remove && hit);
    qty_sum    = 33'(head.qty) + 33'(req_amount);
    if (qty_sum[32] != qty_sum[31]) begin
      qty_sat = qty_sum[32] ? QTY_MIN : QTY_MAX;
    end else begin
      qty_sat = qty_sum[31:0];
    end
    hit_rec = head;
    if (is_adjust) begin
      hit_rec.qty = qty_sat;
    end else if (is_price) begin
      hit_rec.price = req_price;
    end
    priority if (remove_now) begin
      tail_in = head_next;
    end else if (do_insert) begin
      tail_in = '{key: req_key, qty: req_amount, price: req_price};
    end else if (hit) begin
      tail_in = hit_rec;
    end else begin
      tail_in = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      ins_done <= 1'b0;
    end else if (accept) begin
      req_op     <= req.operation;
      req_key    <= req.item_key;
      req_amount <= req.quantity_amount;
      req_price  <= req.price_cents;
      idx        <= '0;
      found      <= 1'b0;
      ins_done   <= 1'b0;
      removing   <= 1'b0;
    end else if (state == S_WALK) begin
      idx      <= idx + 1'b1;
      removing <= remove_now;
      if (hit) begin
        found <= 1'b1;
        old_q <= head.qty;
        old_p <= head.price;
        new_q <= hit_rec.qty;
        new_p <= hit_rec.price;
      end
      if (do_insert) begin
        ins_done <= 1'b1;
        new_q    <= req_amount;
        new_p    <= req_price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_OLD) begin
      sub_en  <= found && (is_adjust || is_price || is_remove);
      add_en  <= (found && (is_adjust || is_price)) || ins_done;
      show_en <= (found && !is_remove) || ins_done;
      if (is_insert) begin
        if (count == FULL_COUNT) begin
          status_r <= ST_FULL;
        end else if (found) begin
          status_r <= ST_DUP;
        end else begin
          status_r <= ST_OK;
        end
      end else begin
        status_r <= found ? ST_OK : ST_MISSING;
      end
    end
  end

  assign mul_q    = (state == S_MUL_OLD) ? old_q : new_q;
  assign mul_p    = (state == S_MUL_OLD) ? old_p : new_p;
  assign mul_full = mul_q * $signed({1'b0, mul_p});
  assign prod_ext = {{7{prod[55]}}, prod};

  always_ff @(posedge clk) begin
    if (state == S_MUL_OLD || state == S_MUL_NEW) begin
      prod <= mul_full[55:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MUL_OLD) begin
        if (ins_done) begin
          count <= count + 1'b1;
        end else if (found && is_remove) begin
          count <= count - 1'b1;
        end
      end
      if (state == S_MUL_NEW && sub_en) begin
        total <= total - prod_ext;
      end
      if (state == S_ADD && add_en) begin
        total <= total + prod_ext;
      end
      if (state == S_FINISH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || rsp.ready)) begin
      out_status <= status_r;
      out_value  <= show_en ? prod : '0;
      out_total  <= total;
      out_count  <= 8'(count);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.item_value  = out_value;
  assign rsp.total_value = out_total;
  assign rsp.entry_count = out_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("record count exceeds table depth");

  a_found_excl: assert property (@(posedge clk) disable iff (rst) !(found && ins_done))
    else $error("insert performed although key was already present");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst) accept |=> state == S_WALK)
    else $error("accepted request did not start a walk");

endmodule

>>> rtl/krt_cell.sv
`timescale 1ns / 1ps
// One storage cell of the record chain: holds a record and takes its neighbor's on a shift.
// Depends on krt_pkg.
module krt_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  krt_pkg::record_t d,
  output krt_pkg::record_t q
);
  import krt_pkg::*;

  record_t rec;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec <= d;
    end
  end

  assign q = rec;

endmodule

>>> rtl/krt_chain.sv
`timescale 1ns / 1ps
// Circular row of record cells; the head cell is presented for matching and the tail is fed back.
// Depends on krt_pkg and krt_cell.
module krt_chain (
  input  logic             clk,
  input  logic             shift_en,
  input  krt_pkg::record_t tail_in,
  output krt_pkg::record_t head,
  output krt_pkg::record_t head_next
);
  import krt_pkg::*;

  record_t cell_q [TABLE_DEPTH];
  record_t cell_d [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign cell_d[k] = tail_in;
    end else begin : g_body
      assign cell_d[k] = cell_q[k+1];
    end
    krt_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (cell_d[k]),
      .q        (cell_q[k])
    );
  end

  assign head = cell_q[0];

  if (TABLE_DEPTH > 1) begin : g_next
    assign head_next = cell_q[1];
  end else begin : g_single
    assign head_next = cell_q[0];
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_record_table_core: request beats are driven from a backlog,
// a shadow copy of the table predicts every response, and response beats are checked in order.
// Depends on krt_pkg, krt_if and the keyed_record_table_core RTL.
module testbench;
  import krt_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam int KEY_POOL_SIZE = 40;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        key;
    logic signed [31:0] amount;
    logic [23:0]        price;
  } request_t;

  typedef struct {
    status_t            status;
    logic signed [55:0] value;
    logic [62:0]        total;
    logic [7:0]         count;
  } response_t;

  logic clk = 1'b0;
  logic rst;
  logic req_taken = 1'b0;

  krt_req_if req_ch();
  krt_rsp_if rsp_ch();

  keyed_record_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t    request_backlog[$];
  response_t   pending_responses[$];
  record_t     shadow_records[$];
  logic [62:0] shadow_total = '0;
  logic [31:0] key_pool[KEY_POOL_SIZE];

  int issued = 0;
  int accepted = 0;
  int checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int peak_records = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  function automatic logic signed [55:0] record_value(record_t r);
    longint prod;
    prod = longint'(r.qty) * longint'(r.price);
    return prod[55:0];
  endfunction

  function automatic response_t table_apply(request_t rq);
    response_t rs;
    record_t rec;
    int slot;
    longint qsum;
    slot = -1;
    foreach (shadow_records[i]) begin
      if (slot < 0 && shadow_records[i].key == rq.key) slot = i;
    end
    rs.status = ST_OK;
    case (rq.op)
      OP_INSERT: begin
        if (shadow_records.size() >= TABLE_DEPTH) begin
          rs.status = ST_FULL;
        end else if (slot >= 0) begin
          rs.status = ST_DUP;
        end else begin
          rec.key = rq.key;
          rec.qty = rq.amount;
          rec.price = rq.price;
          shadow_records.push_back(rec);
          slot = shadow_records.size() - 1;
          shadow_total = shadow_total + 63'(record_value(rec));
        end
      end
      OP_ADJUST, OP_PRICE: begin
        if (slot < 0) begin
          rs.status = ST_MISSING;
        end else begin
          rec = shadow_records[slot];
          shadow_total = shadow_total - 63'(record_value(rec));
          if (rq.op == OP_ADJUST) begin
            qsum = longint'(rec.qty) + longint'(rq.amount);
            if (qsum > longint'(QTY_MAX)) rec.qty = QTY_MAX;
            else if (qsum < longint'(QTY_MIN)) rec.qty = QTY_MIN;
            else rec.qty = qsum[31:0];
          end else begin
            rec.price = rq.price;
          end
          shadow_records[slot] = rec;
          shadow_total = shadow_total + 63'(record_value(rec));
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          rs.status = ST_MISSING;
        end else begin
          shadow_total = shadow_total - 63'(record_value(shadow_records[slot]));
          shadow_records.delete(slot);
          slot = -1;
        end
      end
      default: begin
        if (slot < 0) rs.status = ST_MISSING;
      end
    endcase
    rs.value = (slot >= 0) ? record_value(shadow_records[slot]) : '0;
    rs.total = shadow_total;
    rs.count = 8'(shadow_records.size());
    return rs;
  endfunction

  function automatic request_t random_request(bit draining);
    request_t rq;
    int unsigned pick;
    int unsigned c_ins, c_adj, c_prc, c_rem, c_qry;
    if (draining) begin
      c_ins = 15; c_adj = 27; c_prc = 35; c_rem = 75; c_qry = 93;
    end else begin
      c_ins = 55; c_adj = 67; c_prc = 75; c_rem = 82; c_qry = 95;
    end
    pick = $urandom_range(99);
    if (pick < c_ins) rq.op = OP_INSERT;
    else if (pick < c_adj) rq.op = OP_ADJUST;
    else if (pick < c_prc) rq.op = OP_PRICE;
    else if (pick < c_rem) rq.op = OP_REMOVE;
    else if (pick < c_qry) rq.op = OP_QUERY;
    else rq.op = 3'($urandom_range(OP_RSVD_C, OP_RSVD_A));

    pick = $urandom_range(99);
    if (shadow_records.size() > 0 && pick < 55)
      rq.key = shadow_records[$urandom_range(shadow_records.size() - 1)].key;
    else if (pick < 85)
      rq.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else
      rq.key = $urandom;

    pick = $urandom_range(99);
    if (pick < 20) begin
      case ($urandom_range(4))
        0: rq.amount = QTY_MAX;
        1: rq.amount = QTY_MIN;
        2: rq.amount = '0;
        3: rq.amount = '1;
        default: rq.amount = 32'sd1;
      endcase
    end else if (pick < 60) begin
      rq.amount = 32'($urandom_range(2000)) - 32'd1000;
    end else begin
      rq.amount = $urandom;
    end

    pick = $urandom_range(99);
    if (pick < 15) rq.price = $urandom_range(1) ? '1 : '0;
    else if (pick < 65) rq.price = 24'($urandom_range(99999));
    else rq.price = 24'($urandom);
    return rq;
  endfunction

  task automatic send_request(request_t rq);
    do @(posedge clk); while (request_backlog.size() >= 2);
    request_backlog.push_back(rq);
    issued++;
  endtask

  task automatic wait_drained();
    while (checked != issued) @(negedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_request(random_request(((i / 60) % 2) == 1));
  endtask

  task automatic fill_table();
    request_t rq;
    int n;
    wait_drained();
    n = TABLE_DEPTH - shadow_records.size();
    repeat (n + 2) begin
      rq = random_request(1'b0);
      rq.op = OP_INSERT;
      rq.key = $urandom;
      send_request(rq);
    end
    repeat (3) begin
      rq = random_request(1'b0);
      rq.op = OP_INSERT;
      rq.key = shadow_records[$urandom_range(shadow_records.size() - 1)].key;
      send_request(rq);
    end
  endtask

  always @(negedge clk) begin : request_driver
    request_t taken;
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_taken) begin
        taken.op = req_ch.operation;
        taken.key = req_ch.item_key;
        taken.amount = req_ch.quantity_amount;
        taken.price = req_ch.price_cents;
        pending_responses.push_back(table_apply(taken));
        accepted++;
        if (shadow_records.size() > peak_records) peak_records = shadow_records.size();
      end
      if (!req_ch.valid || req_taken) begin
        if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_backlog.pop_front();
          req_ch.operation <= nxt.op;
          req_ch.item_key <= nxt.key;
          req_ch.quantity_amount <= nxt.amount;
          req_ch.price_cents <= nxt.price;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin : response_receiver
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : response_monitor
    response_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_responses.size() == 0) begin
          $error("response beat arrived with no request outstanding");
          error_count++;
        end else begin
          want = pending_responses.pop_front();
          checked++;
          status_seen[want.status]++;
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.item_value !== want.value) begin
            $error("item_value: expected %0d, got %0d", want.value, rsp_ch.item_value);
            error_count++;
          end
          if (rsp_ch.total_value !== want.total) begin
            $error("total_value: expected %0d, got %0d", $signed(want.total),
                   rsp_ch.total_value);
            error_count++;
          end
          if (rsp_ch.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    request_t directed[$];
    logic [31:0] keys_left[$];
    request_t rq;
    int idx;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_QUERY;
    req_ch.item_key = '0;
    req_ch.quantity_amount = '0;
    req_ch.price_cents = '0;
    rsp_ch.ready = 1'b0;

    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = '{
      '{OP_QUERY,  32'h0000_0000, 32'sd0,        24'h000000},
      '{OP_ADJUST, 32'h7FFF_FFFF, 32'sd5,        24'h000000},
      '{OP_PRICE,  32'h8000_0000, 32'sd0,        24'hFFFFFF},
      '{OP_REMOVE, 32'h0000_0000, 32'sd0,        24'h000000},
      '{OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF},
      '{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF},
      '{OP_INSERT, 32'h0000_0000, 32'sd0,        24'h000000},
      '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h000001},
      '{OP_INSERT, 32'h0000_0000, 32'sd123,      24'h00002D},
      '{OP_ADJUST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h000000},
      '{OP_ADJUST, 32'h8000_0000, 32'h8000_0000, 24'h000000},
      '{OP_ADJUST, 32'hFFFF_FFFF, 32'sd1000,     24'h000000},
      '{OP_PRICE,  32'hFFFF_FFFF, 32'sd0,        24'hFFFFFF},
      '{OP_PRICE,  32'h7FFF_FFFF, 32'sd0,        24'h000000},
      '{OP_RSVD_A, 32'h8000_0000, 32'sd0,        24'h000000},
      '{OP_RSVD_B, 32'h0000_0000, 32'sd0,        24'h000000},
      '{OP_RSVD_C, 32'h0000_1234, 32'sd0,        24'h000000},
      '{OP_REMOVE, 32'h0000_0000, 32'sd0,        24'h000000},
      '{OP_QUERY,  32'hFFFF_FFFF, 32'sd0,        24'h000000},
      '{OP_REMOVE, 32'h7FFF_FFFF, 32'sd0,        24'h000000},
      '{OP_REMOVE, 32'h7FFF_FFFF, 32'sd0,        24'h000000},
      '{OP_QUERY,  32'h8000_0000, 32'sd0,        24'h000000},
      '{OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h800000},
      '{OP_ADJUST, 32'h8000_0000, 32'h7FFF_FFFF, 24'h000000}
    };
    foreach (directed[i]) send_request(directed[i]);

    fill_table();
    run_random(60);
    hold_requests++;
    run_random(240);
    wait_drained();

    send_idle_pct = 83;
    run_random(400);
    wait_drained();
    foreach (shadow_records[i]) keys_left.push_back(shadow_records[i].key);
    while (keys_left.size() > 0) begin
      idx = $urandom_range(keys_left.size() - 1);
      rq = random_request(1'b1);
      rq.op = OP_REMOVE;
      rq.key = keys_left[idx];
      keys_left.delete(idx);
      send_request(rq);
    end
    rq = random_request(1'b1);
    rq.op = OP_QUERY;
    send_request(rq);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 83;
    fill_table();
    run_random(400);
    wait_drained();

    send_idle_pct = 13;
    recv_stall_pct = 13;
    run_random(450);
    wait_drained();

    repeat (TABLE_DEPTH + 20) @(posedge clk);
    $display("summary: %0d requests accepted, %0d responses checked, table peaked at %0d records",
             accepted, checked, peak_records);
    $display("summary: status ok %0d, full %0d, duplicate %0d, missing %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
             status_seen[ST_MISSING]);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/krt_pkg.sv
rtl/krt_if.sv
rtl/krt_cell.sv
rtl/krt_chain.sv
rtl/keyed_record_table_core.sv
tb/testbench.sv
